/* rtl/lcg_signed_bounded_random_defines.svh */
// Assertion macros shared by the generator RTL.
// Compiled away when SYNTHESIS is defined.
`ifndef LCG_SIGNED_BOUNDED_RANDOM_DEFINES_SVH
`define LCG_SIGNED_BOUNDED_RANDOM_DEFINES_SVH
`ifndef SYNTHESIS
`define LSBR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define LSBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LSBR_ASSERT_NOW(lbl, ante, cons, msg)
`define LSBR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/lsbr_pkg.sv */
// Shared constants and types for the signed bounded random generator.
// No dependencies; used by lsbr_div and lcg_signed_bounded_random.
package lsbr_pkg;

   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   localparam logic [31:0] LCG_MUL  = 32'd1103515245;
   localparam logic [31:0] LCG_ADD  = 32'd12345;
   localparam logic [31:0] SIGN_MUL = 32'd12345;
   localparam logic [31:0] SIGN_ADD = 32'd1103515245;
   localparam logic [31:0] SIGN_MOD = 32'd1000;
   localparam logic [10:0] SIGN_MOD_K = 11'd1000;
   localparam logic [10:0] PERCENT_SCALE = 11'd10;

   // ceil(2^38 / 1000): q = (x * RECIP_MUL) >> RECIP_SHIFT for any 32-bit x
   localparam logic [28:0] RECIP_MUL   = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
   } lsbr_div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_W-1:0]  remainder;
   } lsbr_div_rsp_type;

endpackage

/* rtl/lsbr_div.sv */
// Serial restoring divider: one remainder bit per cycle.
// Depends on lsbr_pkg and the assertion macro header.
`include "lcg_signed_bounded_random_defines.svh"

module lsbr_div (
   input  logic                      clock,
   input  logic                      reset,
   input  lsbr_pkg::lsbr_div_req_type div_req,
   output lsbr_pkg::lsbr_div_rsp_type div_rsp
);
   import lsbr_pkg::*;

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       trial;

   assign shifted = {rem_ff, dvd_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         count_in = DIV_CNT_W'(DIV_W);
         busy_in  = 1'b1;
         done_in  = 1'b0;
         rem_in   = '0;
         dvd_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         // keep the shifted value when the trial subtract borrows
         rem_in   = trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_in   = {dvd_ff[DIV_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

   `LSBR_ASSERT_NOW(a_div_rem_below_divisor, done_ff, rem_ff < dvs_ff, "remainder not reduced")
   `LSBR_ASSERT_NOW(a_div_busy_count, busy_ff, count_ff != '0, "busy with zero count")
   `LSBR_ASSERT_NEXT(a_div_start_busy, div_req.start, busy_ff && !done_ff, "start not taken")

endmodule

/* rtl/lcg_signed_bounded_random.sv */
// Signed bounded random source on a 32-bit linear congruential generator.
//
// Channels: req_* carries one command per transfer (req_cmd load or draw,
// req_seed_value, req_limit, req_minus_percent); rsp_* returns exactly one
// result per command (rsp_value, two's complement, and rsp_error).
// A load writes the seed and answers value 0, error 0 in the cycle after the
// transfer. A draw forms a sign word from the old seed, advances the seed,
// and returns (new_seed >> 16) mod limit, negated when sign word mod 1000
// exceeds 10 * req_minus_percent. A zero limit advances the seed and answers
// value 0 with error set. A draw runs through ADVANCE (seed and sign
// multiplies) and RECIP (reciprocal multiply, divider start), then takes the
// remainder by req_limit in a serial restoring divider at one bit per cycle,
// and FINISH loads the output register. The sign reduction runs in parallel
// with the divider. One command is in flight at a time: a draw is taken only
// once the last is done; loads transfer every cycle while rsp_stall is low.
// The result sits in an output register; it holds while rsp_stall is high,
// and a load request can be taken in the cycle the old result leaves.
// Reset (synchronous, active high) clears the seed to zero and empties the
// output register.
// Depends on lsbr_pkg, lsbr_div and the assertion macro header.
`include "lcg_signed_bounded_random_defines.svh"

module lcg_signed_bounded_random (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [31:0]        req_seed_value,
   input  logic [15:0]        req_limit,
   input  logic [6:0]         req_minus_percent,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_value,
   output logic               rsp_error
);
   import lsbr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_RECIP,
      ST_REDUCE,
      ST_FOLD,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        seed_ff, seed_in;
   logic [31:0]        sign_ff, sign_in;
   logic [15:0]        limit_ff, limit_in;
   logic [6:0]         pct_ff, pct_in;
   logic               err_ff, err_in;
   logic [21:0]        quot_ff, quot_in;
   logic [10:0]        kmod_ff, kmod_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [16:0] rsp_value_ff, rsp_value_in;
   logic               rsp_error_ff, rsp_error_in;

   logic               accept;
   logic               out_free;
   logic [31:0]        seed_mul;
   logic [31:0]        sign_mul;
   logic [60:0]        recip_prod;
   logic [31:0]        kprod;
   logic [31:0]        kdiff;
   logic [10:0]        kfold;
   logic [10:0]        thresh;
   logic [16:0]        mag_ext;

   lsbr_div_req_type   div_req;
   lsbr_div_rsp_type   div_rsp;

   lsbr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;

   assign seed_mul   = seed_ff * LCG_MUL + LCG_ADD;
   assign sign_mul   = seed_ff * SIGN_MUL + SIGN_ADD;
   assign recip_prod = {29'b0, sign_ff} * {32'b0, RECIP_MUL};
   assign kprod      = {10'b0, quot_ff} * SIGN_MOD;
   assign kdiff      = sign_ff - kprod;
   assign kfold      = (kmod_ff >= SIGN_MOD_K) ? kmod_ff - SIGN_MOD_K : kmod_ff;
   assign thresh     = {4'b0, pct_ff} * PERCENT_SCALE;
   assign mag_ext    = {1'b0, div_rsp.remainder};

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      sign_in      = sign_ff;
      limit_in     = limit_ff;
      pct_in       = pct_ff;
      err_in       = err_ff;
      quot_in      = quot_ff;
      kmod_in      = kmod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      div_req.start    = 1'b0;
      div_req.dividend = seed_ff[31:16];
      div_req.divisor  = limit_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  seed_in      = req_seed_value;
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_error_in = 1'b0;
               end else begin
                  limit_in = req_limit;
                  pct_in   = req_minus_percent;
                  state_in = ST_ADVANCE;
               end
            end
         end
         ST_ADVANCE: begin
            seed_in  = seed_mul;
            sign_in  = sign_mul;
            err_in   = (limit_ff == '0);
            state_in = (limit_ff == '0) ? ST_FINISH : ST_RECIP;
         end
         ST_RECIP: begin
            div_req.start = 1'b1;
            quot_in  = recip_prod[RECIP_SHIFT+21:RECIP_SHIFT];
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            kmod_in  = kdiff[10:0];
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            neg_in   = kfold > thresh;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the remainder is ready (or the limit was zero) and the output register drains
            if ((err_ff || div_rsp.done) && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_error_in = err_ff;
               if (err_ff) begin
                  rsp_value_in = '0;
               end else if (neg_ff) begin
                  rsp_value_in = $signed(17'd0 - mag_ext);
               end else begin
                  rsp_value_in = $signed(mag_ext);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
      sign_ff      <= sign_in;
      limit_ff     <= limit_in;
      pct_ff       <= pct_in;
      quot_ff      <= quot_in;
      kmod_ff      <= kmod_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   `LSBR_ASSERT_NOW(a_error_value_zero, rsp_valid_ff && rsp_error_ff, rsp_value_ff == '0, "error result carries a value")
   `LSBR_ASSERT_NOW(a_fold_in_range, state_ff == ST_FOLD, kmod_ff < (SIGN_MOD_K + SIGN_MOD_K), "sign reduction out of range")
   `LSBR_ASSERT_NOW(a_finish_waits_div, (state_ff == ST_FINISH) && !err_ff && div_rsp.busy, state_in == ST_FINISH, "result written before remainder")

endmodule

/* sim/tb_lcg_signed_bounded_random.sv */
`timescale 1ns / 100ps
// Self-checking bench for lcg_signed_bounded_random: directed and random load/draw commands
// with random idling on both channels, each result checked against an in-bench generator model.
// Depends on lsbr_pkg (command codes) and the generator RTL.

module tb_lcg_signed_bounded_random;

   localparam logic [31:0] STEP_MUL  = 32'd1103515245;
   localparam logic [31:0] STEP_ADD  = 32'd12345;
   localparam logic [31:0] SGN_MUL   = 32'd12345;
   localparam logic [31:0] SGN_ADD   = 32'd1103515245;
   localparam logic [31:0] SGN_MOD   = 32'd1000;
   localparam logic [31:0] PCT_SCALE = 32'd10;

   localparam int RANDOM_CMDS = 730;
   localparam int CALM_TAIL   = 120;   // no random idling starts once this few commands remain
   localparam int HOLD_AT     = 3000;  // receiver cycle that starts the long hold-off
   localparam int HOLD_LEN    = 300;
   localparam int QUIET_LIMIT = 3000;  // cycles without any transfer before giving up
   localparam int DRAIN       = 40;

   typedef struct {
      logic        cmd;
      logic [31:0] seed_value;
      logic [15:0] limit;
      logic [6:0]  pct;
   } gen_cmd_type;

   typedef struct {
      logic [16:0] value;
      logic        error;
   } gen_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = 1'b0;
   logic [31:0]        req_seed_value = '0;
   logic [15:0]        req_limit = '0;
   logic [6:0]         req_minus_percent = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [16:0] rsp_value;
   logic               rsp_error;

   gen_cmd_type cmd_backlog[$];
   gen_rsp_type owed_results[$];
   logic [31:0] gen_seed = '0;

   int faults = 0;
   int loads = 0;
   int draws = 0;
   int zero_limits = 0;
   int negatives = 0;
   int sent = 0;
   int got = 0;
   int gap_left = 0;
   int rx_cycles = 0;
   int stall_left = 0;
   int hold_left = 0;
   int quiet = 0;

   lcg_signed_bounded_random i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_seed_value    (req_seed_value),
      .req_limit         (req_limit),
      .req_minus_percent (req_minus_percent),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_error         (rsp_error)
   );

   always #5 clock = ~clock;

   // Advance the generator by one command and return the answer it owes.
   function automatic gen_rsp_type roll_lcg(input logic cmd, input logic [31:0] seed_value,
                                            input logic [15:0] limit, input logic [6:0] pct);
      gen_rsp_type r;
      logic [31:0] sign_word;
      logic [15:0] mag;
      logic        neg;
      r.value = '0;
      r.error = 1'b0;
      if (cmd == lsbr_pkg::CMD_LOAD) begin
         gen_seed = seed_value;
         return r;
      end
      sign_word = gen_seed * SGN_MUL + SGN_ADD;
      gen_seed  = gen_seed * STEP_MUL + STEP_ADD;
      // zero limit still advances the seed
      if (limit == '0) begin
         r.error = 1'b1;
         return r;
      end
      mag = gen_seed[31:16] % limit;
      neg = (sign_word % SGN_MOD) > ({25'd0, pct} * PCT_SCALE);
      r.value = neg ? 17'd0 - {1'b0, mag} : {1'b0, mag};
      return r;
   endfunction

   task automatic queue_cmd(input logic cmd, input logic [31:0] seed_value,
                            input logic [15:0] limit, input logic [6:0] pct);
      gen_cmd_type c;
      c.cmd        = cmd;
      c.seed_value = seed_value;
      c.limit      = limit;
      c.pct        = pct;
      cmd_backlog.push_back(c);
   endtask

   task automatic note_fault(input string msg);
      faults++;
      if (faults <= 10) $display("MISMATCH: %s", msg);
   endtask

   // Sender: present the oldest pending command, hold it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            owed_results.push_back(roll_lcg(req_cmd, req_seed_value, req_limit,
                                            req_minus_percent));
            if (req_cmd == lsbr_pkg::CMD_LOAD) loads++;
            else if (req_limit == '0) zero_limits++;
            else draws++;
            void'(cmd_backlog.pop_front());
            sent++;
            if (cmd_backlog.size() > CALM_TAIL && (sent / 64) % 3 != 2 &&
                $urandom_range(0, 2) == 0)
               gap_left = $urandom_range(1, 15);
         end
         if (gap_left > 0 || cmd_backlog.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid         <= 1'b1;
            req_cmd           <= cmd_backlog[0].cmd;
            req_seed_value    <= cmd_backlog[0].seed_value;
            req_limit         <= cmd_backlog[0].limit;
            req_minus_percent <= cmd_backlog[0].pct;
         end
      end
   end

   // Receiver: random stall bursts plus one long hold-off to back up the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles == HOLD_AT) hold_left = HOLD_LEN;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (cmd_backlog.size() > CALM_TAIL && (rx_cycles / 1500) % 3 != 1 &&
                      $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      gen_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got++;
         if (rsp_value[16]) negatives++;
         if (owed_results.size() == 0) begin
            note_fault($sformatf("result %0d with nothing owed: value %0d error %0b",
                                 got, rsp_value, rsp_error));
         end else begin
            want = owed_results.pop_front();
            if (rsp_value !== want.value)
               note_fault($sformatf("result %0d value: expected %0d, got %0d",
                                    got, $signed(want.value), rsp_value));
            if (rsp_error !== want.error)
               note_fault($sformatf("result %0d error: expected %0b, got %0b",
                                    got, want.error, rsp_error));
         end
      end
   end

   // Watchdog: any transfer on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet == QUIET_LIMIT) begin
         $display("watchdog: %0d cycles without a transfer, %0d results still owed",
                  quiet, owed_results.size());
         $display("lcg_signed_bounded_random verification failed");
         $finish;
      end
   end

   initial begin
      int          pick;
      logic        cmd;
      logic [15:0] lim;
      logic [6:0]  pct;

      // directed: reset seed, extreme limits, percent edges, zero limit, ignored fields
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'hFFFF, 7'd0);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'hFFFF_FFFF, 16'd1, 7'd127);
      queue_cmd(lsbr_pkg::CMD_LOAD, 32'hFFFF_FFFF, 16'h0000, 7'd127);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'hFFFF, 7'd127);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'hFFFF, 7'd100);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'hFFFF, 7'd101);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'h0000, 7'd50);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'hFFFF_FFFF, 16'd2, 7'd0);
      queue_cmd(lsbr_pkg::CMD_LOAD, 32'h0000_0000, 16'hFFFF, 7'd0);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'h0000, 7'd0);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'h8000, 7'd99);
      queue_cmd(lsbr_pkg::CMD_LOAD, 32'h8000_0000, 16'd3, 7'd1);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'hA5A5_5A5A, 16'd3, 7'd1);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'hFFFF, 7'd0);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'hFFFE, 7'd0);
      queue_cmd(lsbr_pkg::CMD_LOAD, 32'h1234_5678, 16'd0, 7'd0);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'd7, 7'd50);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'h00FF, 7'd127);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'h0000, 7'd127);
      queue_cmd(lsbr_pkg::CMD_DRAW, 32'h0000_0000, 16'hFFFF, 7'd1);

      for (int i = 0; i < RANDOM_CMDS; i++) begin
         cmd  = ($urandom_range(0, 99) < 10) ? lsbr_pkg::CMD_LOAD : lsbr_pkg::CMD_DRAW;
         pick = $urandom_range(0, 99);
         if (pick < 4) lim = '0;
         else if (pick < 35) lim = 16'($urandom_range(1, 16));
         else if (pick < 55) lim = 16'($urandom_range(1, 1000));
         else lim = 16'($urandom_range(1, 65535));
         pct = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 100));
         queue_cmd(cmd, $urandom, lim, pct);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("covered %0d commands: %0d loads, %0d draws, %0d zero-limit draws",
               sent, loads, draws, zero_limits);
      $display("checked %0d results, %0d negative, %0d mismatches", got, negatives, faults);
      if (faults == 0) begin
         $display("lcg_signed_bounded_random verification clean");
      end else begin
         $display("lcg_signed_bounded_random verification failed");
      end
      $finish;
   end

endmodule
